### src/limit_order_matcher_top_assert.svh
// Assertion macros shared by the checker.
`ifndef LIMIT_ORDER_MATCHER_TOP_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_TOP_ASSERT_SVH

// The antecedent must imply the consequent in the following cycle.
`define LOM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// The condition must hold at every edge out of reset.
`define LOM_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`endif

### src/lom_pkg.sv
`default_nettype none
package lom_pkg;
    localparam int BOOK_DEPTH_DEF  = 16;
    localparam int INSTRUMENTS_DEF = 5;
    localparam int ID_W    = 24;
    localparam int CLIENT_W = 16;
    localparam int QTY_W   = 16;
    localparam int PRICE_W = 24;
    localparam int LOT_W   = 10;
    localparam int INSTR_W = 3;
    localparam int SIDE_W  = 2;

    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_FILL    = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;
    localparam logic [1:0] ST_REJECT  = 2'd3;

    localparam logic [2:0] RSN_NONE  = 3'd0;
    localparam logic [2:0] RSN_SIDE  = 3'd1;
    localparam logic [2:0] RSN_SIZE  = 3'd2;
    localparam logic [2:0] RSN_PRICE = 3'd3;
    localparam logic [2:0] RSN_CLIENT = 3'd4;
    localparam logic [2:0] RSN_INSTR = 3'd5;
    localparam logic [2:0] RSN_FULL  = 3'd6;

    localparam logic [1:0] REG_MIN_QTY = 2'd0;
    localparam logic [1:0] REG_MAX_QTY = 2'd1;
    localparam logic [1:0] REG_LOT     = 2'd2;

    // One resting order.
    typedef struct packed {
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    qty;
        logic [ID_W-1:0]     id;
        logic [CLIENT_W-1:0] client;
    } entry_t;

    // Per-cycle command to every cell of one row.
    typedef struct packed {
        logic               pop;     // drop the front entry, shift toward front
        logic               ins;     // sorted insert of new_e
        logic               upd;     // overwrite front quantity
        logic               is_buy;
        entry_t             new_e;
        logic [QTY_W-1:0]   upd_qty;
    } row_cmd_t;
endpackage
`default_nettype wire

### src/lom_cell.sv
`default_nettype none
// One slot of a book row. Holds an entry, moves it toward or away from the
// front, or takes the incoming order on a sorted insert.
module lom_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  first,
    input  wire                  clr,
    input  wire lom_pkg::row_cmd_t cmd,
    input  wire                  prev_valid,
    input  wire                  prev_goes,   // previous cell insert point at or before it
    input  wire lom_pkg::entry_t prev_e,
    input  wire                  next_valid,
    input  wire lom_pkg::entry_t next_e,
    output logic                 valid,
    output lom_pkg::entry_t      e,
    output logic                 goes
);
    logic            valid_reg, valid_next;
    lom_pkg::entry_t e_reg, e_next;
    logic            beats;

    // New order goes ahead of this entry when it has a strictly better price.
    // Rows stay sorted, so once an entry is beaten every one behind it is too.
    always_comb begin
        beats = !valid_reg ||
                (cmd.is_buy ? (e_reg.price < cmd.new_e.price)
                            : (e_reg.price > cmd.new_e.price));
        goes  = beats;
    end

    always_comb begin
        valid_next = valid_reg;
        e_next     = e_reg;
        if (cmd.pop) begin
            valid_next = next_valid;
            e_next     = next_e;
        end else if (cmd.ins) begin
            if (prev_goes) begin
                valid_next = prev_valid;
                e_next     = prev_e;
            end else if (beats) begin
                valid_next = 1'b1;
                e_next     = cmd.new_e;
            end
        end else if (cmd.upd && first) begin
            e_next.qty = cmd.upd_qty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        e_reg <= e_next;
    end

    assign valid = valid_reg;
    assign e     = e_reg;
endmodule
`default_nettype wire

### src/lom_row.sv
`default_nettype none
// One book: a chain of cells, front cell holds the best price.
module lom_row #(
    parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire lom_pkg::row_cmd_t cmd,
    output logic                   front_valid,
    output lom_pkg::entry_t        front_e,
    output logic                   full
);
    logic            v    [BOOK_DEPTH];
    lom_pkg::entry_t e    [BOOK_DEPTH];
    logic            g    [BOOK_DEPTH];

    for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
        lom_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .first      (i == 0),
            .clr        (1'b0),
            .cmd        (cmd),
            .prev_valid ((i == 0) ? 1'b0 : v[(i == 0) ? 0 : i-1]),
            .prev_goes  ((i == 0) ? 1'b0 : g[(i == 0) ? 0 : i-1]),
            .prev_e     (e[(i == 0) ? 0 : i-1]),
            .next_valid ((i == BOOK_DEPTH-1) ? 1'b0 : v[(i == BOOK_DEPTH-1) ? i : i+1]),
            .next_e     (e[(i == BOOK_DEPTH-1) ? i : i+1]),
            .valid      (v[i]),
            .e          (e[i]),
            .goes       (g[i])
        );
    end

    assign front_valid = v[0];
    assign front_e     = e[0];
    assign full        = v[BOOK_DEPTH-1];
endmodule
`default_nettype wire

### src/limit_order_matcher_top.sv
`default_nettype none
// Limit order matcher, price-time priority. Each s_ beat is one new limit
// order; m_ beats are execution reports, m_tlast on the last one per order.
// Every order takes a sequence number, rejects included. One order is worked
// at a time: the accept, then the lot-size remainder (one quantity bit per
// step), the check, then each match against the opposite book's front cell
// (decide, two report beats; the row moves on during the first beat), and a
// final decision that inserts a resting order through the cell chain or
// rejects it when its own book is full; an order that rests unmatched then
// gets a New report. Output stalls hold every reporting step. Each book is a
// row of BOOK_DEPTH cells that shift in step; no clearing pass is needed
// after reset.
module limit_order_matcher_top #(
    parameter int BOOK_DEPTH  = lom_pkg::BOOK_DEPTH_DEF,
    parameter int INSTRUMENTS = lom_pkg::INSTRUMENTS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Order in.
    input  wire         s_tvalid,
    output logic        s_tready,
    // [15:0] client_tag, [18:16] instrument_index, [20:19] order_side,
    // [36:21] order_quantity, [60:37] limit_price, [63:61] zero
    input  wire  [63:0] s_tdata,
    // Report out.
    output logic        m_tvalid,
    input  wire         m_tready,
    // [23:0] report_order_id, [39:24] report_client, [42:40] report_instrument,
    // [44:43] report_side, [46:45] exec_status, [62:47] exec_quantity,
    // [86:63] exec_price, [89:87] reject_reason, [95:90] zero
    output logic [95:0] m_tdata,
    output logic        m_tlast,  // last_report
    // Configuration.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NBOOKS = 2 * INSTRUMENTS;
    localparam int BK_W   = $clog2(NBOOKS);
    localparam int QW     = lom_pkg::QTY_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOT   = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_MATCH = 7'b0001000,
        S_EMIT1 = 7'b0010000,
        S_EMIT2 = 7'b0100000,
        S_REST  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [QW-1:0]            min_q_reg, max_q_reg;
    logic [lom_pkg::LOT_W-1:0] lot_reg;
    logic                      cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_q_reg <= 16'd10;
            max_q_reg <= 16'd1000;
            lot_reg   <= 10'd10;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                lom_pkg::REG_MIN_QTY: min_q_reg <= pwdata[15:0];
                lom_pkg::REG_MAX_QTY: max_q_reg <= pwdata[15:0];
                lom_pkg::REG_LOT:     lot_reg   <= pwdata[9:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[3:2])
            lom_pkg::REG_MIN_QTY: prdata = {16'd0, min_q_reg};
            lom_pkg::REG_MAX_QTY: prdata = {16'd0, max_q_reg};
            lom_pkg::REG_LOT:     prdata = {22'd0, lot_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // Latched order.
    logic [15:0] client_reg;
    logic [2:0]  instr_reg;
    logic [1:0]  side_reg;
    logic [15:0] qty_reg, rem_reg;
    logic [23:0] price_reg, id_reg, next_id_reg;
    logic        matched_reg;
    // Bit-serial remainder of qty by lot.
    logic [10:0] lrem_reg;
    logic [4:0]  lcnt_reg;
    logic [10:0] lrem_sh;

    // Trade latched for report beats.
    logic [15:0] trade_reg, rq_left_reg;
    lom_pkg::entry_t rest_reg;

    // Output register.
    logic        mv_reg;
    logic [95:0] md_reg;
    logic        ml_reg;

    logic s_acc, m_free;
    assign s_acc  = s_tvalid && s_tready;
    assign m_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    logic is_buy;
    logic [BK_W-1:0] own_bk, opp_bk;
    assign is_buy = (side_reg == lom_pkg::SIDE_BUY);
    assign own_bk = BK_W'({instr_reg, !is_buy});
    assign opp_bk = BK_W'({instr_reg, is_buy});

    // Rows.
    lom_pkg::row_cmd_t cmd    [NBOOKS];
    logic              fv     [NBOOKS];
    lom_pkg::entry_t   fe     [NBOOKS];
    logic              fl     [NBOOKS];
    logic do_pop, do_upd, do_ins;

    for (genvar b = 0; b < NBOOKS; b++) begin : g_book
        always_comb begin
            cmd[b].pop        = do_pop && (opp_bk == BK_W'(b));
            cmd[b].upd        = do_upd && (opp_bk == BK_W'(b));
            cmd[b].ins        = do_ins && (own_bk == BK_W'(b));
            cmd[b].is_buy     = is_buy;
            cmd[b].new_e.price  = price_reg;
            cmd[b].new_e.qty    = rem_reg;
            cmd[b].new_e.id     = id_reg;
            cmd[b].new_e.client = client_reg;
            cmd[b].upd_qty    = rq_left_reg;
        end
        lom_row #(.BOOK_DEPTH(BOOK_DEPTH)) u_row (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd[b]),
            .front_valid (fv[b]),
            .front_e     (fe[b]),
            .full        (fl[b])
        );
    end

    logic            ofv, own_full;
    lom_pkg::entry_t ofe;
    assign ofv      = fv[opp_bk];
    assign ofe      = fe[opp_bk];
    assign own_full = fl[own_bk];

    logic can_match;
    assign can_match = ofv && (is_buy ? (ofe.price <= price_reg)
                                      : (ofe.price >= price_reg));
    logic [15:0] trade_c;
    assign trade_c = (ofe.qty < rem_reg) ? ofe.qty : rem_reg;

    // Check result.
    logic [2:0] reason;
    always_comb begin
        reason = lom_pkg::RSN_NONE;
        if (side_reg != lom_pkg::SIDE_BUY && side_reg != lom_pkg::SIDE_SELL)
            reason = lom_pkg::RSN_SIDE;
        else if (qty_reg == 16'd0 || qty_reg < min_q_reg || qty_reg > max_q_reg ||
                 (lot_reg != '0 && lrem_reg != '0))
            reason = lom_pkg::RSN_SIZE;
        else if (price_reg == '0)
            reason = lom_pkg::RSN_PRICE;
        else if (client_reg == '0)
            reason = lom_pkg::RSN_CLIENT;
        else if (32'(instr_reg) >= 32'(INSTRUMENTS))
            reason = lom_pkg::RSN_INSTR;
    end

    function automatic logic [95:0] pack(input logic [23:0] id, input logic [15:0] cl,
                                         input logic [2:0] ins, input logic [1:0] sd,
                                         input logic [1:0] st, input logic [15:0] q,
                                         input logic [23:0] pr, input logic [2:0] rs);
        pack = {6'd0, rs, pr, q, st, sd, ins, cl, id};
    endfunction

    logic        emit;
    logic [95:0] emit_d;
    logic        emit_l;

    assign lrem_sh = {lrem_reg[9:0], qty_reg[4'd15 - lcnt_reg[3:0]]};

    always_comb begin
        state_next = state_reg;
        emit = 1'b0; emit_d = '0; emit_l = 1'b0;
        do_pop = 1'b0; do_upd = 1'b0; do_ins = 1'b0;
        unique case (state_reg)
            S_IDLE:  if (s_acc) state_next = S_LOT;
            S_LOT:   if (lcnt_reg == 5'd16) state_next = S_CHECK;
            S_CHECK: begin
                if (reason != lom_pkg::RSN_NONE) begin
                    if (m_free) begin
                        emit = 1'b1; emit_l = 1'b1;
                        emit_d = pack(id_reg, client_reg, instr_reg, side_reg,
                                      lom_pkg::ST_REJECT, qty_reg, price_reg, reason);
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH: begin
                if (rem_reg != '0 && can_match) begin
                    state_next = S_EMIT1;
                end else if (rem_reg == '0) begin
                    state_next = S_IDLE;
                end else if (own_full) begin
                    if (m_free) begin
                        emit = 1'b1; emit_l = 1'b1;
                        emit_d = pack(id_reg, client_reg, instr_reg, side_reg,
                                      lom_pkg::ST_REJECT, rem_reg, price_reg,
                                      lom_pkg::RSN_FULL);
                        state_next = S_IDLE;
                    end
                end else begin
                    do_ins = 1'b1;
                    state_next = matched_reg ? S_IDLE : S_REST;
                end
            end
            S_EMIT1: if (m_free) begin
                emit = 1'b1;
                emit_d = pack(id_reg, client_reg, instr_reg, side_reg,
                              (rem_reg == '0) ? lom_pkg::ST_FILL : lom_pkg::ST_PARTIAL,
                              trade_reg, rest_reg.price, lom_pkg::RSN_NONE);
                // Row moves on now, so the next front is visible during the
                // second beat.
                if (rq_left_reg == '0) do_pop = 1'b1;
                else                   do_upd = 1'b1;
                state_next = S_EMIT2;
            end
            S_EMIT2: if (m_free) begin
                emit = 1'b1;
                emit_d = pack(rest_reg.id, rest_reg.client, instr_reg,
                              is_buy ? lom_pkg::SIDE_SELL : lom_pkg::SIDE_BUY,
                              (rq_left_reg == '0) ? lom_pkg::ST_FILL : lom_pkg::ST_PARTIAL,
                              trade_reg, rest_reg.price, lom_pkg::RSN_NONE);
                // Last beat unless another match or a full-book reject follows;
                // a remainder that rests quietly sends nothing more.
                emit_l = (rem_reg == '0) || (!can_match && !own_full);
                state_next = S_MATCH;
            end
            S_REST: if (m_free) begin
                emit = 1'b1; emit_l = 1'b1;
                emit_d = pack(id_reg, client_reg, instr_reg, side_reg,
                              lom_pkg::ST_NEW, qty_reg, price_reg, lom_pkg::RSN_NONE);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mv_reg      <= 1'b0;
            next_id_reg <= 24'd1;
        end else begin
            state_reg <= state_next;
            if (emit)          mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
            if (s_acc) next_id_reg <= (next_id_reg == 24'hFFFFFF) ? 24'd1 : next_id_reg + 24'd1;
        end
    end

    // Output data path.
    always_ff @(posedge aclk) begin
        if (emit) begin
            md_reg <= emit_d;
            ml_reg <= emit_l;
        end
    end

    // Order and trade capture.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            client_reg  <= s_tdata[15:0];
            instr_reg   <= s_tdata[18:16];
            side_reg    <= s_tdata[20:19];
            qty_reg     <= s_tdata[36:21];
            rem_reg     <= s_tdata[36:21];
            price_reg   <= s_tdata[60:37];
            id_reg      <= next_id_reg;
            matched_reg <= 1'b0;
            lrem_reg    <= '0;
            lcnt_reg    <= '0;
        end
        if (state_reg == S_LOT && lcnt_reg != 5'd16) begin
            lrem_reg <= (lrem_sh >= {1'b0, lot_reg}) ? lrem_sh - {1'b0, lot_reg} : lrem_sh;
            lcnt_reg <= lcnt_reg + 5'd1;
        end
        if (state_reg == S_MATCH && rem_reg != '0 && can_match) begin
            trade_reg   <= trade_c;
            rq_left_reg <= ofe.qty - trade_c;
            rem_reg     <= rem_reg - trade_c;
            rest_reg    <= ofe;
            matched_reg <= 1'b1;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
endmodule
`default_nettype wire

### src/lom_checker.sv
`default_nettype none
`include "limit_order_matcher_top_assert.svh"
// Port-level checks on the matcher.
module lom_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [95:0] m_tdata,
    input wire        m_tlast,
    input wire        pready
);
    `LOM_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "report beat changed while stalled")
    `LOM_ASSERT_ALWAYS(a_pready, aclk, aresetn, pready, "pready low")
    `LOM_ASSERT_ALWAYS(a_reason, aclk, aresetn, !m_tvalid || (m_tdata[46:45] == lom_pkg::ST_REJECT) || (m_tdata[89:87] == lom_pkg::RSN_NONE), "reason on non-reject")
    `LOM_ASSERT_ALWAYS(a_rej_last, aclk, aresetn, !m_tvalid || (m_tdata[46:45] != lom_pkg::ST_REJECT) || m_tlast, "reject not last")
    `LOM_ASSERT_ALWAYS(a_id, aclk, aresetn, !m_tvalid || (m_tdata[23:0] != 24'd0), "zero order id")
endmodule

bind limit_order_matcher_top lom_checker u_lom_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
`default_nettype wire
